// ===== rtl/dfzp_pkg.sv =====
// dfzp_pkg: shared constants, codes and types of the dilated fir block
// used by dfzp_ctrl, dfzp_dp and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package dfzp_pkg;

	// default values of the top level parameters
	localparam int MAX_TAPS       = 8;
	localparam int MAX_STRIDE     = 4;
	localparam int COEF_FRAC_BITS = 14;

	// fixed field and register widths
	localparam int SAMPLE_W  = 16;
	localparam int TAP_W     = 16;
	localparam int TAP_SLOTS = 8;
	localparam int TAP_IDX_W = $clog2(TAP_SLOTS);
	localparam int CNT_W     = 4;
	localparam int STRIDE_W  = 3;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TAP_COUNT  = 2'd0,
		CFG_TAP_STRIDE = 2'd1,
		CFG_TAPS_LOW   = 2'd2,
		CFG_TAPS_HIGH  = 2'd3
	} cfg_idx_t;

	localparam logic [CNT_W-1:0]    RST_TAP_COUNT  = 4'd1;
	localparam logic [STRIDE_W-1:0] RST_TAP_STRIDE = 3'd1;
	localparam logic [CFG_W-1:0]    RST_TAPS_LOW   = 64'd16384;
	localparam logic [CFG_W-1:0]    RST_TAPS_HIGH  = 64'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MAC,
		ST_DRAIN,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic push;
		logic push_zero;
		logic row_clear;
		logic mac_start;
		logic mac_issue;
		logic out_load;
		logic run_last;
		logic row_last;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic above_lag;
		logic issue_last;
		logic out_free;
	} dp_status_t;

	function automatic logic signed [TAP_W-1:0] tap_sel(
		input logic [2*CFG_W-1:0]   taps,
		input logic [TAP_IDX_W-1:0] k
	);
		logic [TAP_W-1:0] raw;
		raw = taps[k*TAP_W +: TAP_W];
		return signed'(raw);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dfzp_ram.sv =====
// dfzp_ram: generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dfzp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/dfzp_ctrl.sv =====
// dfzp_ctrl: sequencer of the dilated fir; push, tap walk, drain, output, flush
// depends on dfzp_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfzp_ctrl #(
	parameter int MAX_TAPS   = dfzp_pkg::MAX_TAPS,
	parameter int MAX_STRIDE = dfzp_pkg::MAX_STRIDE
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tlast,
	output logic                        s_tready,
	input  wire logic [$clog2((MAX_TAPS/2)*MAX_STRIDE+2)-1:0] lag,
	input  wire dfzp_pkg::dp_status_t   status,
	output dfzp_pkg::ctrl_cmd_t         cmd
);

	localparam int LAG_MAX = (MAX_TAPS / 2) * MAX_STRIDE;
	localparam int LAG_W   = $clog2(LAG_MAX + 2);

	dfzp_pkg::state_t state_q, state_d;
	logic             row_end_q, row_end_d;
	logic [LAG_W-1:0] rem_q, rem_d;
	logic             drain_q, drain_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dfzp_pkg::ST_IDLE;
			row_end_q <= 1'b0;
			rem_q     <= '0;
			drain_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			row_end_q <= row_end_d;
			rem_q     <= rem_d;
			drain_q   <= drain_d;
		end
	end

	always_comb begin
		logic adv;
		adv       = 1'b0;
		state_d   = state_q;
		row_end_d = row_end_q;
		rem_d     = rem_q;
		drain_d   = drain_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			dfzp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.push  = 1'b1;
					row_end_d = s_tlast;
					rem_d     = lag;
					state_d   = dfzp_pkg::ST_CHECK;
				end
			end
			dfzp_pkg::ST_CHECK: begin
				if (status.above_lag) begin
					cmd.mac_start = 1'b1;
					state_d       = dfzp_pkg::ST_MAC;
				end else begin
					adv = 1'b1;
				end
			end
			dfzp_pkg::ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (status.issue_last) begin
					drain_d = 1'b0;
					state_d = dfzp_pkg::ST_DRAIN;
				end
			end
			dfzp_pkg::ST_DRAIN: begin
				// read and multiply stages still in flight
				drain_d = 1'b1;
				if (drain_q) begin
					state_d = dfzp_pkg::ST_OUT;
				end
			end
			dfzp_pkg::ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.run_last = !row_end_q || (rem_q == '0);
					cmd.row_last = row_end_q && (rem_q == '0);
					adv          = 1'b1;
				end
			end
			default: begin
				state_d = dfzp_pkg::ST_IDLE;
			end
		endcase
		// after a sample: either push the next flush zero or go back for a word
		if (adv) begin
			if (row_end_q && (rem_q != '0)) begin
				cmd.push_zero = 1'b1;
				rem_d         = rem_q - LAG_W'(1);
				state_d       = dfzp_pkg::ST_CHECK;
			end else begin
				cmd.row_clear = row_end_q;
				state_d       = dfzp_pkg::ST_IDLE;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dfzp_dp.sv =====
// dfzp_dp: sample history ram, shared multiply-accumulate, round/saturate, output register
// depends on dfzp_pkg and dfzp_ram
`timescale 1ns / 1ps
`default_nettype none

module dfzp_dp #(
	parameter int MAX_TAPS       = dfzp_pkg::MAX_TAPS,
	parameter int MAX_STRIDE     = dfzp_pkg::MAX_STRIDE,
	parameter int COEF_FRAC_BITS = dfzp_pkg::COEF_FRAC_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire dfzp_pkg::ctrl_cmd_t                   cmd,
	input  wire logic [dfzp_pkg::SAMPLE_W-1:0]         sample,
	input  wire logic [dfzp_pkg::CNT_W-1:0]            n_taps,
	input  wire logic [dfzp_pkg::STRIDE_W-1:0]         stride,
	input  wire logic [$clog2((MAX_TAPS/2)*MAX_STRIDE+2)-1:0] lag,
	input  wire logic [2*dfzp_pkg::CFG_W-1:0]          taps,
	output dfzp_pkg::dp_status_t                       status,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [dfzp_pkg::SAMPLE_W-1:0]              value,
	output logic                                       clipped,
	output logic                                       run_last,
	output logic                                       row_last
);

	localparam int LAG_MAX    = (MAX_TAPS / 2) * MAX_STRIDE;
	localparam int HIST_DEPTH = 2 * LAG_MAX + 1;
	localparam int AW         = $clog2(HIST_DEPTH + 1);
	localparam int PROD_W     = 2 * dfzp_pkg::SAMPLE_W;
	localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS) + 1;
	localparam int TIW        = dfzp_pkg::TAP_IDX_W;

	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-16){1'b0}}, 16'h7fff};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-16){1'b1}}, 16'h8000};
	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

	// history ring: newest word sits at wp_q - 1, fill_q words of this row are live
	logic [AW-1:0] wp_q;
	logic [AW-1:0] fill_q;
	logic [AW-1:0] idx_q;
	logic [TIW-1:0] k_q;

	logic                               ram_we;
	logic [dfzp_pkg::SAMPLE_W-1:0]      ram_wdata;
	logic [AW-1:0]                      ram_raddr;
	logic [dfzp_pkg::SAMPLE_W-1:0]      ram_rdata;

	logic                               en_s1, ok_s1;
	logic signed [dfzp_pkg::TAP_W-1:0]  tap_s1;
	logic                               en_s2;
	logic signed [PROD_W-1:0]           prod_s2;
	logic signed [ACC_W-1:0]            acc_q;
	logic signed [dfzp_pkg::SAMPLE_W-1:0] x_s1;

	logic signed [ACC_W-1:0]            rnd_sum, shifted;
	logic                               sat_hi, sat_lo;

	logic                               vld_q;
	logic [dfzp_pkg::SAMPLE_W-1:0]      value_q;
	logic                               clipped_q, run_last_q, row_last_q;

	assign ram_we    = cmd.push || cmd.push_zero;
	assign ram_wdata = cmd.push ? sample : '0;
	assign ram_raddr = wp_q - AW'(1) - idx_q;

	dfzp_ram #(
		.WIDTH (dfzp_pkg::SAMPLE_W),
		.DEPTH (2**AW)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			idx_q  <= '0;
			k_q    <= '0;
			en_s1  <= 1'b0;
			en_s2  <= 1'b0;
		end else begin
			if (ram_we) begin
				wp_q <= wp_q + AW'(1);
			end
			if (cmd.row_clear) begin
				fill_q <= '0;
			end else if (ram_we && (fill_q != AW'(HIST_DEPTH))) begin
				fill_q <= fill_q + AW'(1);
			end
			if (cmd.mac_start) begin
				idx_q <= AW'({lag, 1'b0});
				k_q   <= '0;
			end else if (cmd.mac_issue) begin
				idx_q <= idx_q - AW'(stride);
				k_q   <= k_q + TIW'(1);
			end
			en_s1 <= cmd.mac_issue;
			en_s2 <= en_s1;
		end
	end

	// tap pipeline payload
	always_ff @(posedge clk) begin
		ok_s1   <= idx_q < fill_q;
		tap_s1  <= dfzp_pkg::tap_sel(taps, k_q);
		prod_s2 <= tap_s1 * x_s1;
		if (cmd.mac_start) begin
			acc_q <= '0;
		end else if (en_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// entries older than the row read as zero
	assign x_s1 = ok_s1 ? signed'(ram_rdata) : '0;

	// round half up, floor shift, saturate
	assign rnd_sum = acc_q + RND;
	assign shifted = rnd_sum >>> COEF_FRAC_BITS;
	assign sat_hi  = shifted > SAT_HI;
	assign sat_lo  = shifted < SAT_LO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q    <= sat_hi ? 16'h7fff : (sat_lo ? 16'h8000 : shifted[15:0]);
			clipped_q  <= sat_hi || sat_lo;
			run_last_q <= cmd.run_last;
			row_last_q <= cmd.row_last;
		end
	end

	assign status.above_lag  = fill_q > AW'(lag);
	assign status.issue_last = ({1'b0, k_q} + (TIW+1)'(1)) == (TIW+1)'(n_taps);
	assign status.out_free   = !vld_q || m_tready;

	assign m_tvalid = vld_q;
	assign value    = value_q;
	assign clipped  = clipped_q;
	assign run_last = run_last_q;
	assign row_last = row_last_q;

endmodule

`default_nettype wire

// ===== rtl/dilated_fir_zero_padded.sv =====
// dilated_fir_zero_padded: top level; configuration registers, controller and datapath
// depends on dfzp_pkg, dfzp_ctrl, dfzp_dp, dfzp_ram
//
// Filters one row of signed 16-bit samples with up to eight dilated Q1.14 taps;
// samples outside the row count as zero.
// Input stream: s_tdata = sample, s_tlast = last sample of the row.
// Output stream: m_tdata = filtered value, m_tuser = {run_last, clipped},
// m_tlast = final output of the row.
// Configuration: cfg_we writes cfg_data to register cfg_index at the clock edge
// (0 tap_count, 1 tap_stride, 2 taps 0..3, 3 taps 4..7); write only while idle.
// Sequence: a sample is taken and the history fill is checked; while the fill
// does not exceed the lag the sample gives no output. Otherwise, with n taps in
// use, one history ram read per tap runs through one shared multiply-accumulate,
// followed by a pipeline drain and an output load. A row-end sample then pushes
// h * stride flush zeros (h = n/2), each handled the same way; the next sample
// is taken only once the block is back in idle.
// The output register decouples the sides: s_tready returns while a word still
// waits on m_tready; a stalled receiver holds the block only when the next
// word is ready to load.
// Reset clears the registers to one unit tap at stride one and empties the row.
`timescale 1ns / 1ps
`default_nettype none

module dilated_fir_zero_padded #(
	parameter int MAX_TAPS       = dfzp_pkg::MAX_TAPS,
	parameter int MAX_STRIDE     = dfzp_pkg::MAX_STRIDE,
	parameter int COEF_FRAC_BITS = dfzp_pkg::COEF_FRAC_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [15:0]                      s_tdata,   // sample
	input  wire logic                             s_tlast,   // row_end
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [15:0]                           m_tdata,   // value
	output logic [1:0]                            m_tuser,   // run_last, clipped
	output logic                                  m_tlast,   // row_last
	input  wire logic                             cfg_we,
	input  wire logic [dfzp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dfzp_pkg::CFG_W-1:0]       cfg_data
);

	localparam int LAG_MAX = (MAX_TAPS / 2) * MAX_STRIDE;
	localparam int LAG_W   = $clog2(LAG_MAX + 2);

	logic [dfzp_pkg::CNT_W-1:0]    tap_count_q;
	logic [dfzp_pkg::STRIDE_W-1:0] tap_stride_q;
	logic [dfzp_pkg::CFG_W-1:0]    taps_low_q, taps_high_q;

	logic [dfzp_pkg::CNT_W-1:0]    n_eff;
	logic [dfzp_pkg::STRIDE_W-1:0] s_eff;
	logic [5:0]                    lag_prod;
	logic [LAG_W-1:0]              lag;

	dfzp_pkg::ctrl_cmd_t  cmd;
	dfzp_pkg::dp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= dfzp_pkg::RST_TAP_COUNT;
			tap_stride_q <= dfzp_pkg::RST_TAP_STRIDE;
			taps_low_q   <= dfzp_pkg::RST_TAPS_LOW;
			taps_high_q  <= dfzp_pkg::RST_TAPS_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				dfzp_pkg::CFG_TAP_COUNT:  tap_count_q  <= cfg_data[dfzp_pkg::CNT_W-1:0];
				dfzp_pkg::CFG_TAP_STRIDE: tap_stride_q <= cfg_data[dfzp_pkg::STRIDE_W-1:0];
				dfzp_pkg::CFG_TAPS_LOW:   taps_low_q   <= cfg_data;
				dfzp_pkg::CFG_TAPS_HIGH:  taps_high_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// zero means one, anything above the maximum is clamped
	always_comb begin
		if (tap_count_q == '0) begin
			n_eff = dfzp_pkg::CNT_W'(1);
		end else if (int'(tap_count_q) > MAX_TAPS) begin
			n_eff = dfzp_pkg::CNT_W'(MAX_TAPS);
		end else begin
			n_eff = tap_count_q;
		end
		if (tap_stride_q == '0) begin
			s_eff = dfzp_pkg::STRIDE_W'(1);
		end else if (int'(tap_stride_q) > MAX_STRIDE) begin
			s_eff = dfzp_pkg::STRIDE_W'(MAX_STRIDE);
		end else begin
			s_eff = tap_stride_q;
		end
	end

	assign lag_prod = 6'(n_eff[dfzp_pkg::CNT_W-1:1]) * 6'(s_eff);
	assign lag      = LAG_W'(lag_prod);

	dfzp_ctrl #(
		.MAX_TAPS   (MAX_TAPS),
		.MAX_STRIDE (MAX_STRIDE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.lag      (lag),
		.status   (status),
		.cmd      (cmd)
	);

	dfzp_dp #(
		.MAX_TAPS       (MAX_TAPS),
		.MAX_STRIDE     (MAX_STRIDE),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (s_tdata),
		.n_taps   (n_eff),
		.stride   (s_eff),
		.lag      (lag),
		.taps     ({taps_high_q, taps_low_q}),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.value    (m_tdata),
		.clipped  (m_tuser[0]),
		.run_last (m_tuser[1]),
		.row_last (m_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/dfzp_checker.sv =====
// dfzp_checker: port-level assertions of the dilated fir, bound to the top level
// depends on dilated_fir_zero_padded
`timescale 1ns / 1ps
`default_nettype none

module dfzp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	// a stalled output word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// one sample at a time: ready drops after each accepted word
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// the last word of a row also closes its run
	a_row_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tlast || m_tuser[1]))
		else $error("row end without run end");

	// a clipped word carries a rail value
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
		else $error("clipped word off the rails");

endmodule

bind dilated_fir_zero_padded dfzp_checker u_dfzp_checker (.*);

`default_nettype wire
